// File: rtl/core/tslw_pkg.sv
// Package for the twist slew limiter with watchdog.
// Holds field widths, action/status/register codes and the configuration struct.
// No dependencies.
package tslw_pkg;

    localparam int unsigned VEL_W   = 16;
    localparam int unsigned LIM_W   = 15;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned IVL_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Input action codes
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_UPDATE  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_LIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_ANG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd5;

    // Register reset values
    localparam logic [LIM_W-1:0]  RST_MAX_LIN  = 15'd3277;
    localparam logic [LIM_W-1:0]  RST_MAX_ANG  = 15'd10240;
    localparam logic [ACC_W-1:0]  RST_ACC_LIN  = 16'd3355;
    localparam logic [ACC_W-1:0]  RST_ACC_ANG  = 16'd12583;
    localparam logic [IVL_W-1:0]  RST_INTERVAL = 16'd20;
    localparam logic [TIME_W-1:0] RST_TIMEOUT  = 32'd350;

    typedef struct packed {
        logic [LIM_W-1:0]  max_linear;
        logic [LIM_W-1:0]  max_angular;
        logic [ACC_W-1:0]  accel_linear;
        logic [ACC_W-1:0]  accel_angular;
        logic [IVL_W-1:0]  update_interval;
        logic [TIME_W-1:0] command_timeout;
    } t_cfg;

endpackage

// File: rtl/core/tslw_cmd_if.sv
// Input channel: action, time stamp and commanded velocity.
// Depends on tslw_pkg.
interface tslw_cmd_if;
    import tslw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [TIME_W-1:0]        now_ms;
    logic signed [VEL_W-1:0]  cmd_vx;
    logic signed [VEL_W-1:0]  cmd_vy;
    logic signed [VEL_W-1:0]  cmd_wz;

    modport source (output valid, action, now_ms, cmd_vx, cmd_vy, cmd_wz, input ready);
    modport sink   (input valid, action, now_ms, cmd_vx, cmd_vy, cmd_wz, output ready);
endinterface

// File: rtl/core/tslw_res_if.sv
// Result channel: status and current ramped velocity.
// Depends on tslw_pkg.
interface tslw_res_if;
    import tslw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [VEL_W-1:0]  out_vx;
    logic signed [VEL_W-1:0]  out_vy;
    logic signed [VEL_W-1:0]  out_wz;

    modport source (output valid, status, out_vx, out_vy, out_wz, input ready);
    modport sink   (input valid, status, out_vx, out_vy, out_wz, output ready);
endinterface

// File: rtl/core/tslw_cfg.sv
// Configuration register bank, written through a plain write port.
// Depends on tslw_pkg.
module tslw_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tslw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tslw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tslw_pkg::t_cfg                    o_cfg
);
    import tslw_pkg::*;

    t_cfg r_cfg;

    // Register writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_linear      <= RST_MAX_LIN;
            r_cfg.max_angular     <= RST_MAX_ANG;
            r_cfg.accel_linear    <= RST_ACC_LIN;
            r_cfg.accel_angular   <= RST_ACC_ANG;
            r_cfg.update_interval <= RST_INTERVAL;
            r_cfg.command_timeout <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_LIN:  r_cfg.max_linear      <= i_cfg_data[LIM_W-1:0];
                REG_MAX_ANG:  r_cfg.max_angular     <= i_cfg_data[LIM_W-1:0];
                REG_ACC_LIN:  r_cfg.accel_linear    <= i_cfg_data[ACC_W-1:0];
                REG_ACC_ANG:  r_cfg.accel_angular   <= i_cfg_data[ACC_W-1:0];
                REG_INTERVAL: r_cfg.update_interval <= i_cfg_data[IVL_W-1:0];
                REG_TIMEOUT:  r_cfg.command_timeout <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// File: rtl/core/tslw_ramp.sv
// Ramp step size: (accel * elapsed) >> 10, saturated to 16 bits.
// Depends on tslw_pkg.
module tslw_ramp (
    input  logic [tslw_pkg::ACC_W-1:0]  i_accel,
    input  logic [tslw_pkg::TIME_W-1:0] i_elapsed,
    output logic [tslw_pkg::VEL_W-1:0]  o_delta
);
    import tslw_pkg::*;

    localparam int unsigned PROD_W = ACC_W + TIME_W;

    logic [PROD_W-1:0]    w_prod;
    logic [PROD_W-11:0]   w_scaled;

    // 16 x 32 product, drop the 10 fraction bits
    assign w_prod   = PROD_W'(i_accel) * PROD_W'(i_elapsed);
    assign w_scaled = w_prod[PROD_W-1:10];

    // Saturate at full 16-bit step
    assign o_delta = (|w_scaled[PROD_W-11:VEL_W]) ? {VEL_W{1'b1}} : w_scaled[VEL_W-1:0];
endmodule

// File: rtl/core/tslw_axis.sv
// One axis: move the current velocity toward the goal by at most delta.
// Depends on tslw_pkg.
module tslw_axis (
    input  logic signed [tslw_pkg::VEL_W-1:0] i_cur,
    input  logic signed [tslw_pkg::VEL_W-1:0] i_goal,
    input  logic [tslw_pkg::VEL_W-1:0]        i_delta,
    output logic signed [tslw_pkg::VEL_W-1:0] o_next
);
    import tslw_pkg::*;

    localparam int unsigned EXT_W = VEL_W + 2;

    logic signed [EXT_W-1:0] w_cur;
    logic signed [EXT_W-1:0] w_goal;
    logic signed [EXT_W-1:0] w_delta;
    logic signed [EXT_W-1:0] w_up;
    logic signed [EXT_W-1:0] w_dn;

    // Widened so cur +/- delta cannot wrap
    assign w_cur   = EXT_W'(i_cur);
    assign w_goal  = EXT_W'(i_goal);
    assign w_delta = $signed({2'b00, i_delta});
    assign w_up    = w_cur + w_delta;
    assign w_dn    = w_cur - w_delta;

    // Bounded step; a clipped result always lies between cur and goal
    always_comb begin
        if (w_goal > w_up) begin
            o_next = w_up[VEL_W-1:0];
        end else if (w_goal < w_dn) begin
            o_next = w_dn[VEL_W-1:0];
        end else begin
            o_next = i_goal;
        end
    end
endmodule

// File: rtl/core/twist_slew_limiter_with_watchdog_core.sv
// Top level of the twist slew limiter with watchdog.
// Depends on tslw_pkg, tslw_cmd_if, tslw_res_if, tslw_cfg, tslw_ramp, tslw_axis.

// Velocity slew limiter with command watchdog. Each transaction on i_cmd
// (command, tick or stop) yields exactly one transaction on o_res carrying a
// status and the current ramped vx, vy, wz (signed Q4.12). A transaction is
// captured in an input register and resolved by single-pass logic (clamp,
// one 16x32 multiply per axis class, bounded step) into the result register
// once it is free, which also updates the goal/current state, so one
// transaction per cycle is sustained while o_res is ready; o_res.valid is
// driven from the result register. Backpressure on o_res holds the result
// register; one more transaction can wait in the input register, after which
// i_cmd.ready drops until o_res drains.
// Time is modular 32-bit milliseconds. Configuration is written through
// i_cfg_we/i_cfg_idx/i_cfg_data and must only change while the block is idle.
module twist_slew_limiter_with_watchdog_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tslw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tslw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tslw_cmd_if.sink                          i_cmd,
    tslw_res_if.source                        o_res
);
    import tslw_pkg::*;

    t_cfg w_cfg;

    // Input register
    logic                     r_in_valid;
    logic [1:0]               r_in_action;
    logic [TIME_W-1:0]        r_in_now;
    logic signed [VEL_W-1:0]  r_in_vx;
    logic signed [VEL_W-1:0]  r_in_vy;
    logic signed [VEL_W-1:0]  r_in_wz;

    // Block state
    logic signed [VEL_W-1:0]  r_goal_vx, r_goal_vy, r_goal_wz;
    logic signed [VEL_W-1:0]  r_now_vx, r_now_vy, r_now_wz;
    logic [TIME_W-1:0]        r_last_upd;
    logic [TIME_W-1:0]        r_last_cmd;
    logic                     r_force;
    logic                     r_running;

    logic signed [VEL_W-1:0]  n_goal_vx, n_goal_vy, n_goal_wz;
    logic signed [VEL_W-1:0]  n_now_vx, n_now_vy, n_now_wz;
    logic [TIME_W-1:0]        n_last_upd;
    logic [TIME_W-1:0]        n_last_cmd;
    logic                     n_force;
    logic                     n_running;
    logic [1:0]               n_status;

    // Result register
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic signed [VEL_W-1:0]  r_out_vx, r_out_vy, r_out_wz;

    logic                     w_adv;
    logic                     w_fire;
    logic [TIME_W-1:0]        w_since_cmd;
    logic [TIME_W-1:0]        w_since_upd;
    logic [TIME_W-1:0]        w_elapsed;
    logic                     w_timeout;
    logic                     w_due;
    logic [VEL_W-1:0]         w_dlin;
    logic [VEL_W-1:0]         w_dang;
    logic signed [VEL_W-1:0]  w_step_vx, w_step_vy, w_step_wz;

    function automatic logic signed [VEL_W-1:0] clamp_sym(
        input logic signed [VEL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [VEL_W:0] v_x;
        logic signed [VEL_W:0] hi;
        logic signed [VEL_W:0] res;
        v_x = (VEL_W+1)'(v);
        hi  = $signed({2'b00, lim});
        if (v_x < -hi) begin
            res = -hi;
        end else if (v_x > hi) begin
            res = hi;
        end else begin
            res = v_x;
        end
        return res[VEL_W-1:0];
    endfunction

    tslw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Handshake: result register drains or is empty -> pipeline advances
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_cmd.ready = !r_in_valid || w_adv;
    assign w_fire      = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_action <= i_cmd.action;
            r_in_now    <= i_cmd.now_ms;
            r_in_vx     <= i_cmd.cmd_vx;
            r_in_vy     <= i_cmd.cmd_vy;
            r_in_wz     <= i_cmd.cmd_wz;
        end
    end

    // Watchdog and interval checks in modular time
    assign w_since_cmd = r_in_now - r_last_cmd;
    assign w_since_upd = r_in_now - r_last_upd;
    assign w_timeout   = r_running && (w_since_cmd > w_cfg.command_timeout);
    assign w_due       = r_running
                         && (r_force || (w_since_upd >= TIME_W'(w_cfg.update_interval)));
    // First update after reset uses the nominal interval
    assign w_elapsed   = (r_last_upd == '0) ? TIME_W'(w_cfg.update_interval) : w_since_upd;

    tslw_ramp u_ramp_lin (
        .i_accel   (w_cfg.accel_linear),
        .i_elapsed (w_elapsed),
        .o_delta   (w_dlin)
    );

    tslw_ramp u_ramp_ang (
        .i_accel   (w_cfg.accel_angular),
        .i_elapsed (w_elapsed),
        .o_delta   (w_dang)
    );

    tslw_axis u_axis_vx (.i_cur(r_now_vx), .i_goal(r_goal_vx), .i_delta(w_dlin),
                         .o_next(w_step_vx));
    tslw_axis u_axis_vy (.i_cur(r_now_vy), .i_goal(r_goal_vy), .i_delta(w_dlin),
                         .o_next(w_step_vy));
    tslw_axis u_axis_wz (.i_cur(r_now_wz), .i_goal(r_goal_wz), .i_delta(w_dang),
                         .o_next(w_step_wz));

    // Next state per action
    always_comb begin
        n_goal_vx  = r_goal_vx;
        n_goal_vy  = r_goal_vy;
        n_goal_wz  = r_goal_wz;
        n_now_vx   = r_now_vx;
        n_now_vy   = r_now_vy;
        n_now_wz   = r_now_wz;
        n_last_upd = r_last_upd;
        n_last_cmd = r_last_cmd;
        n_force    = r_force;
        n_running  = r_running;
        n_status   = ST_NONE;
        case (r_in_action)
            ACT_CMD: begin
                n_goal_vx  = clamp_sym(r_in_vx, w_cfg.max_linear);
                n_goal_vy  = clamp_sym(r_in_vy, w_cfg.max_linear);
                n_goal_wz  = clamp_sym(r_in_wz, w_cfg.max_angular);
                n_force    = 1'b1;
                n_last_cmd = r_in_now;
                n_running  = 1'b1;
            end
            ACT_STOP: begin
                n_goal_vx = '0;
                n_goal_vy = '0;
                n_goal_wz = '0;
                n_now_vx  = '0;
                n_now_vy  = '0;
                n_now_wz  = '0;
                n_force   = 1'b1;
                n_running = 1'b0;
            end
            ACT_TICK: begin
                if (w_timeout) begin
                    n_goal_vx = '0;
                    n_goal_vy = '0;
                    n_goal_wz = '0;
                    n_now_vx  = '0;
                    n_now_vy  = '0;
                    n_now_wz  = '0;
                    n_force   = 1'b1;
                    n_running = 1'b0;
                    n_status  = ST_TIMEOUT;
                end else if (w_due) begin
                    n_now_vx   = w_step_vx;
                    n_now_vy   = w_step_vy;
                    n_now_wz   = w_step_wz;
                    n_last_upd = r_in_now;
                    n_force    = 1'b0;
                    n_status   = ST_UPDATE;
                end
            end
            default: begin
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_vx   <= '0;
            r_goal_vy   <= '0;
            r_goal_wz   <= '0;
            r_now_vx    <= '0;
            r_now_vy    <= '0;
            r_now_wz    <= '0;
            r_last_upd  <= '0;
            r_last_cmd  <= '0;
            r_force     <= 1'b1;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_goal_vx  <= n_goal_vx;
                r_goal_vy  <= n_goal_vy;
                r_goal_wz  <= n_goal_wz;
                r_now_vx   <= n_now_vx;
                r_now_vy   <= n_now_vy;
                r_now_wz   <= n_now_wz;
                r_last_upd <= n_last_upd;
                r_last_cmd <= n_last_cmd;
                r_force    <= n_force;
                r_running  <= n_running;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_out_vx <= n_now_vx;
            r_out_vy <= n_now_vy;
            r_out_wz <= n_now_wz;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_status;
    assign o_res.out_vx = r_out_vx;
    assign o_res.out_vy = r_out_vy;
    assign o_res.out_wz = r_out_wz;

    // A timeout result always reports a stopped chassis
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_TIMEOUT)
            |-> (o_res.out_vx == '0 && o_res.out_vy == '0 && o_res.out_wz == '0))
        else $error("timeout result with nonzero velocity");

    // An idle block never reports a ramp update
    a_idle_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_running) |=> (r_status != ST_UPDATE))
        else $error("ramp update while not running");

    // A ramp update clears the forced-update flag
    a_force_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_action == ACT_TICK && !w_timeout && w_due) |=> !r_force)
        else $error("force flag not cleared by update");

    // An empty result register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_cmd.ready)
        else $error("input stalled with empty result register");

    // A stalled result holds the state
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_now_vx) && $stable(r_running))
        else $error("state changed while result stalled");
endmodule
